// ===== hdl/cat_command_frame_encoder_macros.svh =====
// Assertion helpers shared by the encoder's modules.
`ifndef CAT_COMMAND_FRAME_ENCODER_MACROS_SVH
`define CAT_COMMAND_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define CCFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define CCFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ccfe_pkg.sv =====
package ccfe_pkg;

    localparam int KindW   = 3;
    localparam int FreqW   = 30;
    localparam int ByteW   = 8;

    // Command kinds
    localparam logic [KindW-1:0] KindCtrlOn  = 3'd0;
    localparam logic [KindW-1:0] KindCtrlOff = 3'd1;
    localparam logic [KindW-1:0] KindSatOn   = 3'd2;
    localparam logic [KindW-1:0] KindSatOff  = 3'd3;
    localparam logic [KindW-1:0] KindRxFreq  = 3'd4;
    localparam logic [KindW-1:0] KindTxFreq  = 3'd5;

    // Opcode bytes, sent last in each frame
    localparam logic [ByteW-1:0] OpCtrlOn  = 8'h00;
    localparam logic [ByteW-1:0] OpCtrlOff = 8'h80;
    localparam logic [ByteW-1:0] OpSatOn   = 8'h4e;
    localparam logic [ByteW-1:0] OpSatOff  = 8'h8e;
    localparam logic [ByteW-1:0] OpRxFreq  = 8'h11;
    localparam logic [ByteW-1:0] OpTxFreq  = 8'h21;

    localparam logic [FreqW-1:0] FreqMaxHz   = 30'd999999994;
    localparam logic [FreqW-1:0] FreqRoundHz = 30'd5;

    // Binary to BCD: nine digits cover any value below 10^9
    localparam int BcdDigits   = 9;
    localparam int BcdW        = 4 * BcdDigits;
    localparam int FrameBcdW   = 32;
    localparam int BitsPerStep = 6;
    localparam int DabbleSteps = FreqW / BitsPerStep;
    localparam int StepW       = $clog2(DabbleSteps);

    // Frame sequencing
    localparam int FrameLen = 5;
    localparam int IdxW     = $clog2(FrameLen);
    localparam logic [IdxW-1:0] FrameLastIdx = IdxW'(FrameLen - 1);

    localparam int CmdQueueDepth = 4;

    typedef struct packed {
        logic [FreqW-1:0] value;
        logic [ByteW-1:0] opcode;
    } t_cmd;

    typedef struct packed {
        logic [FrameBcdW-1:0] bcd;
        logic [ByteW-1:0]     opcode;
    } t_frame;

    // One shift-and-add-3 step, taking in one bit of the binary value
    function automatic logic [BcdW-1:0] dabble_bit(input logic [BcdW-1:0] bcd,
                                                    input logic bin_bit);
        logic [BcdW-1:0] adj;
        adj = bcd;
        for (int d = 0; d < BcdDigits; d++) begin
            if (adj[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BcdW-2:0], bin_bit};
    endfunction

endpackage

// ===== hdl/ccfe_front.sv =====
module ccfe_front (
    input  logic [ccfe_pkg::KindW-1:0] i_kind,
    input  logic [ccfe_pkg::FreqW-1:0] i_frequency_hz,
    input  logic                       i_push,
    input  logic                       i_queue_full,
    output logic                       o_full,
    output logic                       o_wr,
    output ccfe_pkg::t_cmd             o_cmd
);

    logic                       is_freq;
    logic                       kind_ok;
    logic [ccfe_pkg::FreqW-1:0] sat_hz;

    assign is_freq = (i_kind == ccfe_pkg::KindRxFreq) || (i_kind == ccfe_pkg::KindTxFreq);
    assign kind_ok = (i_kind <= ccfe_pkg::KindTxFreq);
    assign sat_hz  = (i_frequency_hz > ccfe_pkg::FreqMaxHz) ? ccfe_pkg::FreqMaxHz
                                                             : i_frequency_hz;

    assign o_full = i_queue_full;
    // Drop unused kinds: accepted but never queued
    assign o_wr   = i_push && !i_queue_full && kind_ok;

    // Adding half a step makes the top eight digits the rounded value
    always_comb begin
        o_cmd.value = is_freq ? (sat_hz + ccfe_pkg::FreqRoundHz) : '0;
        case (i_kind)
            ccfe_pkg::KindCtrlOn:  o_cmd.opcode = ccfe_pkg::OpCtrlOn;
            ccfe_pkg::KindCtrlOff: o_cmd.opcode = ccfe_pkg::OpCtrlOff;
            ccfe_pkg::KindSatOn:   o_cmd.opcode = ccfe_pkg::OpSatOn;
            ccfe_pkg::KindSatOff:  o_cmd.opcode = ccfe_pkg::OpSatOff;
            ccfe_pkg::KindRxFreq:  o_cmd.opcode = ccfe_pkg::OpRxFreq;
            ccfe_pkg::KindTxFreq:  o_cmd.opcode = ccfe_pkg::OpTxFreq;
            default:               o_cmd.opcode = ccfe_pkg::OpCtrlOn;
        endcase
    end

endmodule

// ===== hdl/ccfe_fifo.sv =====
`include "cat_command_frame_encoder_macros.svh"

module ccfe_fifo #(
    parameter int DEPTH = ccfe_pkg::CmdQueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  ccfe_pkg::t_cmd i_cmd,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_empty,
    output ccfe_pkg::t_cmd o_cmd
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    ccfe_pkg::t_cmd  r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full   = (r_count == CntFull);
    assign o_empty  = (r_count == '0);
    assign o_cmd    = r_mem[r_rd_ptr];
    assign n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_rd) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CCFE_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_wr, !o_full, "queue written while full")
    `CCFE_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_rd, !o_empty, "queue read while empty")

endmodule

// ===== hdl/ccfe_bcd.sv =====
`include "cat_command_frame_encoder_macros.svh"

module ccfe_bcd (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  ccfe_pkg::t_cmd   i_cmd,
    output logic             o_rd,
    output logic             o_res_valid,
    output ccfe_pkg::t_frame o_res,
    input  logic             i_take
);

    typedef enum logic {
        S_IDLE,
        S_CONV
    } t_state;

    t_state                         r_state;
    logic [ccfe_pkg::StepW-1:0]     r_step;
    logic [ccfe_pkg::FreqW-1:0]     r_bin;
    logic [ccfe_pkg::BcdW-1:0]      r_bcd, n_bcd;
    logic [ccfe_pkg::ByteW-1:0]     r_op;
    logic                           r_res_valid;
    ccfe_pkg::t_frame               r_res;
    logic                           last_step;
    logic                           finish;
    logic                           load;

    // Several dabble steps per cycle, top bits of the binary value first
    always_comb begin
        n_bcd = r_bcd;
        for (int i = 0; i < ccfe_pkg::BitsPerStep; i++) begin
            n_bcd = ccfe_pkg::dabble_bit(n_bcd, r_bin[ccfe_pkg::FreqW-1-i]);
        end
    end

    assign last_step = (r_state == S_CONV) &&
                       (r_step == ccfe_pkg::StepW'(ccfe_pkg::DabbleSteps - 1));
    assign finish    = last_step && (!r_res_valid || i_take);
    assign load      = ((r_state == S_IDLE) || finish) && !i_empty;

    assign o_rd        = load;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_res_valid  <= 1'b1;
                // Units digit dropped: the rest is the value in tens of hertz
                r_res.bcd    <= n_bcd[ccfe_pkg::BcdW-1 -: ccfe_pkg::FrameBcdW];
                r_res.opcode <= r_op;
            end else if (i_take) begin
                r_res_valid <= 1'b0;
            end

            if (load) begin
                r_state <= S_CONV;
                r_step  <= '0;
                r_bin   <= i_cmd.value;
                r_bcd   <= '0;
                r_op    <= i_cmd.opcode;
            end else if (finish) begin
                r_state <= S_IDLE;
            end else if ((r_state == S_CONV) && !last_step) begin
                r_step <= r_step + 1'b1;
                r_bin  <= r_bin << ccfe_pkg::BitsPerStep;
                r_bcd  <= n_bcd;
            end
        end
    end

    `CCFE_ASSERT_NEXT(a_res_held, i_clk, i_rst_n, r_res_valid && !i_take, r_res_valid && $stable(r_res), "pending frame lost or changed")

endmodule

// ===== hdl/ccfe_emit.sv =====
`include "cat_command_frame_encoder_macros.svh"

module ccfe_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_res_valid,
    input  ccfe_pkg::t_frame           i_res,
    output logic                       o_take,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [ccfe_pkg::ByteW-1:0] o_frame_byte,
    output logic                       o_frame_last
);

    logic                      r_valid;
    logic [ccfe_pkg::IdxW-1:0] r_idx;
    ccfe_pkg::t_frame          r_frame;
    logic                      at_last;
    logic                      advance;

    assign at_last = (r_idx == ccfe_pkg::FrameLastIdx);
    assign advance = r_valid && i_pop;
    assign o_take  = i_res_valid && (!r_valid || (advance && at_last));

    assign o_empty      = !r_valid;
    assign o_frame_last = at_last;

    always_comb begin
        case (r_idx)
            3'd0:    o_frame_byte = r_frame.bcd[31:24];
            3'd1:    o_frame_byte = r_frame.bcd[23:16];
            3'd2:    o_frame_byte = r_frame.bcd[15:8];
            3'd3:    o_frame_byte = r_frame.bcd[7:0];
            default: o_frame_byte = r_frame.opcode;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_take) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
            r_frame <= i_res;
        end else if (advance) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    `CCFE_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, r_valid, r_idx <= ccfe_pkg::FrameLastIdx, "byte index past end of frame")
    `CCFE_ASSERT_NEXT(a_drain, i_clk, i_rst_n, advance && at_last && !i_res_valid, !r_valid, "frame output not released after last byte")

endmodule

// ===== hdl/cat_command_frame_encoder.sv =====
// Channel   Direction  Handshake             Word
// command   in         i_push / o_full       i_kind, i_frequency_hz
// frame     out        o_empty / i_pop       o_frame_byte, o_frame_last
//
// The BCD converter works through a command six shift-and-add-3 steps a cycle
// over the 30-bit value. Frames then leave at one byte a cycle while i_pop is
// held, and the converter works on the next command while a frame's bytes go out.
// Reset (synchronous, active low) empties the queue and the output; no clearing pass.
// Either side may stall: the command queue and the pending-frame register absorb it.
module cat_command_frame_encoder #(
    parameter int QUEUE_DEPTH = ccfe_pkg::CmdQueueDepth
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [ccfe_pkg::KindW-1:0] i_kind,
    input  logic [ccfe_pkg::FreqW-1:0] i_frequency_hz,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [ccfe_pkg::ByteW-1:0] o_frame_byte,
    output logic                       o_frame_last
);

    logic             q_full, q_empty, q_wr, q_rd;
    ccfe_pkg::t_cmd   wr_cmd, rd_cmd;
    logic             res_valid, res_take;
    ccfe_pkg::t_frame res;

    // Front: classify, saturate and pre-round; drop unused kinds
    ccfe_front u_front (
        .i_kind         (i_kind),
        .i_frequency_hz (i_frequency_hz),
        .i_push         (i_push),
        .i_queue_full   (q_full),
        .o_full         (o_full),
        .o_wr           (q_wr),
        .o_cmd          (wr_cmd)
    );

    // Hold classified commands so the front keeps accepting while the back works
    ccfe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (wr_cmd),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (rd_cmd)
    );

    // Back, first half: binary to packed BCD, overlapped with the byte output
    ccfe_bcd u_bcd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (rd_cmd),
        .o_rd        (q_rd),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_take      (res_take)
    );

    // Back, second half: advance through the five bytes on each pop
    ccfe_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .o_take       (res_take),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

endmodule
